// ===== sv/gc_pkg.sv =====
// gc_pkg: shared types, register and channel codes, constant tables
// for the gamma correction pipeline (log2 difference table, exp2 coefficients)
// no dependencies
package gc_pkg;

    // pixel transfer payloads
    typedef struct packed {
        logic [7:0] chan0_in;
        logic [7:0] chan1_in;
        logic [7:0] chan2_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] chan0_out;
        logic [7:0] chan1_out;
        logic [7:0] chan2_out;
    } pixel_out_t;

    // configuration register indexes
    localparam logic REG_CHANNEL_SELECT = 1'b0;
    localparam logic REG_INVERSE_GAMMA  = 1'b1;

    // channel codes
    localparam logic [1:0] CH0     = 2'd0;
    localparam logic [1:0] CH1     = 2'd1;
    localparam logic [1:0] CH2     = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam int FRAC_BITS    = 16;
    localparam int LOG_W        = 19;
    localparam int R_W          = 31;
    localparam int COEF_W       = 30;
    localparam int EXP_STAGES   = FRAC_BITS;
    // input transfer to result strobe, in clock edges
    localparam int PIPE_LATENCY = EXP_STAGES + 3;

    localparam logic [R_W-1:0] R_ONE = R_W'(1) << 30;

    // item traveling down the exp2 multiply chain
    typedef struct packed {
        logic             valid;
        logic [1:0]       sel;
        logic             kill;   // corrected channel forced to zero
        logic [3:0]       shift;  // integer part of the exponent, 0..8 unless kill is set
        pixel_in_t        pix;
        logic [15:0]      fp;     // remaining exponent fraction bits, msb next
        logic [R_W-1:0]   r;      // running product, q1.30
    } exp_item_t;

    typedef logic [LOG_W-1:0]  log_tab_t [256];
    typedef logic [COEF_W-1:0] coef_tab_t [EXP_STAGES+1];

    // log2 of v in 1..255, 16 fraction bits, by repeated squaring
    function automatic logic [LOG_W-1:0] log2_q16(input int unsigned v);
        logic [63:0] m;
        logic [2:0]  top;
        logic [15:0] frac;
        top  = 3'd0;
        frac = 16'd0;
        for (int i = 1; i < 8; i++)
        begin
            if ((v >> i) != 0)
                top = 3'(i);
        end
        m = 64'(v) << (FRAC_BITS - int'(top));
        for (int k = FRAC_BITS - 1; k >= 0; k--)
        begin
            m = (m * m) >> FRAC_BITS;
            if (m >= 64'h20000)
            begin
                m = m >> 1;
                frac[k] = 1'b1;
            end
        end
        return {top, frac};
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        t[0] = '0;
        for (int v = 1; v < 256; v++)
            t[v] = log2_q16(255) - log2_q16(v);
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] val;
        res = '0;
        b   = 64'd1 << 62;
        val = v;
        for (int i = 0; i < 32; i++)
        begin
            if (b > val)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (val >= res + b)
                begin
                    val = val - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // c_k = 2^(-2^-k) in q0.30
    function automatic coef_tab_t build_coef_tab();
        coef_tab_t   c;
        logic [63:0] s;
        c[0] = COEF_W'(1) << 29;
        for (int k = 1; k <= EXP_STAGES; k++)
        begin
            s    = isqrt64(64'(c[k-1]) << 30);
            c[k] = s[COEF_W-1:0];
        end
        return c;
    endfunction

    // log2(255) - log2(x), indexed by x
    localparam log_tab_t  LOG_DIFF = build_log_tab();
    localparam coef_tab_t EXP_COEF = build_coef_tab();

endpackage

// ===== sv/single_channel_gamma_correction.sv =====
// single_channel_gamma_correction: top level, config registers and pipeline
// depends on gc_pkg, gc_front, gc_exp_step, gc_back
//
//   channel   ports                            transfer when
//   -------   ------------------------------   ---------------------------
//   pixel in  start, busy, pixel               start high and busy low
//   pixel out done, result                     every cycle done is high
//   config    cfg_we, cfg_addr, cfg_wdata      cfg_we high
//
// one pixel per clock, every clock; busy is always low
// from the input transfer to the done strobe a pixel passes two front
// stages (log2 table, exponent multiply), sixteen exp2 multiply
// stages and one output stage; the exp2 product chain sets the depth
// reset clears the valid bits and sets channel_select to 0 and
// inverse_gamma to 1.0
// the receiver cannot stall, so nothing ever holds inside the pipeline
module single_channel_gamma_correction
    import gc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        start,
    output logic        busy,
    input  pixel_in_t   pixel,
    // pixel output
    output logic        done,
    output pixel_out_t  result,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [1:0]  channel_select_reg;
    logic [15:0] inverse_gamma_reg;

    // stage[0] leaves the front end, stage[k] leaves exp step k
    exp_item_t   stage [EXP_STAGES+1];

    // never stalls
    assign busy = 1'b0;

    // configuration registers, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_select_reg <= CH0;
            inverse_gamma_reg  <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_wdata[1:0];
                REG_INVERSE_GAMMA:  inverse_gamma_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // log2(255) - log2(x), times 1/gamma
    gc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .pix            (pixel),
        .channel_select (channel_select_reg),
        .inverse_gamma  (inverse_gamma_reg),
        .item           (stage[0])
    );

    // 2^-frac, one fraction bit per stage, highest weight first
    for (genvar k = 0; k < EXP_STAGES; k++)
    begin : g_exp
        gc_exp_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .item_in  (stage[k]),
            .coef     (EXP_COEF[k+1]),
            .item_out (stage[k+1])
        );
    end

    // scale by 255, shift by the integer exponent, merge channels
    gc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (stage[EXP_STAGES]),
        .done   (done),
        .result (result)
    );

    // every input transfer yields exactly one strobe once it has passed through the pipeline
    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("missing result strobe");

    a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe with no input transfer");

    // a zero in channel 0 stays zero whether or not it is corrected
    a_zero_stays_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(pixel.chan0_in, PIPE_LATENCY) == 8'd0)
            |-> result.chan0_out == 8'd0)
        else $error("zero channel corrected to nonzero");

    // with no channel selected the pixel passes untouched
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (done && channel_select_reg == CH_NONE)
            |-> result == pixel_out_t'($past(pixel, PIPE_LATENCY)))
        else $error("pixel altered with no channel selected");

endmodule

// ===== sv/gc_front.sv =====
// gc_front: pixel capture with log2 table lookup, then exponent scaling
// two register stages; depends on gc_pkg
module gc_front
    import gc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  pixel_in_t   pix,
    input  logic [1:0]  channel_select,
    input  logic [15:0] inverse_gamma,
    output exp_item_t   item
);

    logic             s1_valid_reg;
    logic [1:0]       s1_sel_reg;
    pixel_in_t        s1_pix_reg;
    logic [LOG_W-1:0] s1_n_reg;
    logic             s1_zero_reg;

    logic [7:0]       x_sel;
    logic [34:0]      prod;
    logic [22:0]      p;
    exp_item_t        item_reg;
    exp_item_t        item_next;

    always_comb
    begin
        case (channel_select)
            CH0:     x_sel = pix.chan0_in;
            CH1:     x_sel = pix.chan1_in;
            CH2:     x_sel = pix.chan2_in;
            default: x_sel = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_sel_reg  <= channel_select;
        s1_pix_reg  <= pix;
        s1_n_reg    <= LOG_DIFF[x_sel];
        s1_zero_reg <= (x_sel == 8'd0);
    end

    // exponent magnitude, 16 fraction bits
    assign prod = 35'(s1_n_reg) * 35'(inverse_gamma);
    assign p    = prod[34:12];

    always_comb
    begin
        item_next.valid = s1_valid_reg;
        item_next.sel   = s1_sel_reg;
        item_next.kill  = s1_zero_reg || (p[22:16] > 7'd8);
        item_next.shift = p[19:16];
        item_next.pix   = s1_pix_reg;
        item_next.fp    = p[15:0];
        item_next.r     = R_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

// ===== sv/gc_exp_step.sv =====
// gc_exp_step: one stage of the exp2 product chain, one q1.30 by q0.30 multiply
// depends on gc_pkg
module gc_exp_step
    import gc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  exp_item_t         item_in,
    input  logic [COEF_W-1:0] coef,
    output exp_item_t         item_out
);

    logic [R_W+COEF_W-1:0] prod;
    exp_item_t             item_reg;
    exp_item_t             item_next;

    assign prod = (R_W+COEF_W)'(item_in.r) * (R_W+COEF_W)'(coef);

    always_comb
    begin
        item_next    = item_in;
        // next fraction bit moves to the top
        item_next.fp = {item_in.fp[14:0], 1'b0};
        if (item_in.fp[15])
            item_next.r = prod[R_W+COEF_W-1:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item_out = item_reg;

endmodule

// ===== sv/gc_back.sv =====
// gc_back: full-scale multiply, exponent shift and channel merge
// depends on gc_pkg
module gc_back
    import gc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  exp_item_t  item,
    output logic       done,
    output pixel_out_t result
);

    logic [R_W+7:0] scaled;
    logic [R_W+7:0] shifted;
    logic [7:0]     value;
    logic           done_reg;
    pixel_out_t     result_reg;
    pixel_out_t     result_next;

    // 255 * r
    assign scaled  = {item.r, 8'd0} - {8'd0, item.r};
    assign shifted = scaled >> (6'd30 + 6'(item.shift));
    assign value   = item.kill ? 8'd0 : shifted[7:0];

    always_comb
    begin
        result_next.chan0_out = (item.sel == CH0) ? value : item.pix.chan0_in;
        result_next.chan1_out = (item.sel == CH1) ? value : item.pix.chan1_in;
        result_next.chan2_out = (item.sel == CH2) ? value : item.pix.chan2_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/testbench.sv =====
// testbench for single_channel_gamma_correction: queue-fed pixel driver, result monitor,
// and a bit-exact fixed-point predictor of the gamma curve
// depends on gc_pkg and the single_channel_gamma_correction rtl
`timescale 1ns / 100ps

module testbench
    import gc_pkg::*;
;

    // stalls with no transfer of any kind before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // cycles to let the pipeline settle after the last result
    localparam int SETTLE      = PIPE_LATENCY + 2;

    typedef enum logic [1:0] {ACT_PIXEL, ACT_WRITE, ACT_DRAIN} act_t;

    typedef struct {
        act_t        act;
        pixel_in_t   pix;
        logic        addr;
        logic [15:0] data;
        int          gap_pct;   // chance per cycle that the sender idles
    } plan_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    pixel_in_t   pixel     = '0;
    logic        done;
    pixel_out_t  result;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;

    plan_item_t  input_plan [$];   // stimulus not yet transferred
    pixel_out_t  pixels_due [$];   // predicted pixels, oldest first

    // register copies kept by the predictor, at their reset values
    logic [1:0]  sel_model    = CH0;
    logic [15:0] igamma_model = 16'd4096;
    logic [63:0] exp2_coef [0:16];

    logic        pix_taken    = 1'b0;
    int          settle_cnt   = 0;
    int          quiet_cycles = 0;
    int          mismatches   = 0;

    single_channel_gamma_correction i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor of the square root, built one result bit at a time
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // 2^(-2^-k) in q0.30, each one the truncated root of the one before
    task automatic build_exp2_coef();
        exp2_coef[0] = 64'd1 << 29;
        for (int k = 1; k <= 16; k++)
            exp2_coef[k] = floor_sqrt(exp2_coef[k-1] << 30);
    endtask

    // log2 with 16 fraction bits: integer part from the top set bit,
    // fraction from repeated squaring of the q1.16 mantissa
    function automatic logic [31:0] log2_fix(input logic [7:0] v);
        logic [63:0] m;
        int          top;
        logic [15:0] frac;
        top  = 0;
        frac = '0;
        for (int b = 0; b < 8; b++)
            if (v[b])
                top = b;
        m = 64'(v) << (16 - top);
        for (int k = 15; k >= 0; k--)
        begin
            m = (m * m) >> 16;
            if (m >= 64'h2_0000)
            begin
                m       = m >> 1;
                frac[k] = 1'b1;
            end
        end
        return (32'(top) << 16) | 32'(frac);
    endfunction

    // floor(255 * (x/255)^(1/gamma)) with every step truncated
    function automatic logic [7:0] gamma_channel(input logic [7:0] x, input logic [15:0] ig);
        logic [31:0] n;
        logic [63:0] p;
        logic [63:0] ip;
        logic [15:0] fp;
        logic [63:0] r;
        if (x == 8'd0)
            return 8'd0;
        n  = log2_fix(8'd255) - log2_fix(x);
        p  = (64'(n) * 64'(ig)) >> 12;
        ip = p >> 16;
        fp = p[15:0];
        // exponent too large, the result underflows
        if (ip > 64'd8)
            return 8'd0;
        r = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (fp[16-k])
                r = (r * exp2_coef[k]) >> 30;
        r = (64'd255 * r) >> (30 + ip);
        return r[7:0];
    endfunction

    function automatic pixel_out_t gamma_pixel(input pixel_in_t px);
        pixel_out_t o;
        o.chan0_out = (sel_model == CH0) ? gamma_channel(px.chan0_in, igamma_model) : px.chan0_in;
        o.chan1_out = (sel_model == CH1) ? gamma_channel(px.chan1_in, igamma_model) : px.chan1_in;
        o.chan2_out = (sel_model == CH2) ? gamma_channel(px.chan2_in, igamma_model) : px.chan2_in;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus plan
    // ------------------------------------------------------------------

    task automatic plan_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input int gap);
        plan_item_t it;
        it.act     = ACT_PIXEL;
        it.pix     = '{chan0_in: c0, chan1_in: c1, chan2_in: c2};
        it.addr    = 1'b0;
        it.data    = '0;
        it.gap_pct = gap;
        input_plan.push_back(it);
    endtask

    // register writes only go in behind a full drain of the pipeline
    task automatic plan_config(input logic [1:0] sel, input logic [15:0] ig);
        plan_item_t it;
        it.pix     = '0;
        it.gap_pct = 0;
        it.act     = ACT_DRAIN;
        it.addr    = 1'b0;
        it.data    = '0;
        input_plan.push_back(it);
        // upper bits of the select write are junk the block must drop
        it.act  = ACT_WRITE;
        it.addr = REG_CHANNEL_SELECT;
        it.data = {14'($urandom), sel};
        input_plan.push_back(it);
        it.addr = REG_INVERSE_GAMMA;
        it.data = ig;
        input_plan.push_back(it);
    endtask

    // channel values leaning on the ends of the range
    function automatic logic [7:0] pick_level();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(1, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_igamma();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hffff;
            3:       return 16'd4096;
            4:       return 16'($urandom_range(1024, 16384));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: everything changes at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        logic        nxt_start;
        pixel_in_t   nxt_pix;
        logic        nxt_we;
        logic        nxt_addr;
        logic [15:0] nxt_data;
        nxt_start = 1'b0;
        nxt_pix   = pixel;
        nxt_we    = 1'b0;
        nxt_addr  = cfg_addr;
        nxt_data  = cfg_wdata;
        if (rst_n)
        begin
            // retire what went across at the last rising edge
            if (start && pix_taken)
                void'(input_plan.pop_front());
            if (cfg_we)
                void'(input_plan.pop_front());
            if (input_plan.size() != 0)
            begin
                case (input_plan[0].act)
                    ACT_PIXEL:
                    begin
                        if (start && !pix_taken)
                        begin
                            // offered but not taken: keep it on the bus
                            nxt_start = 1'b1;
                        end
                        else if ($urandom_range(99) >= input_plan[0].gap_pct)
                        begin
                            nxt_start = 1'b1;
                            nxt_pix   = input_plan[0].pix;
                        end
                    end
                    ACT_WRITE:
                    begin
                        nxt_we   = 1'b1;
                        nxt_addr = input_plan[0].addr;
                        nxt_data = input_plan[0].data;
                    end
                    default:
                    begin
                        // hold off until every predicted pixel is back,
                        // then let the pipeline go quiet
                        if (pixels_due.size() == 0)
                        begin
                            if (settle_cnt >= SETTLE)
                            begin
                                settle_cnt = 0;
                                void'(input_plan.pop_front());
                            end
                            else
                            begin
                                settle_cnt++;
                            end
                        end
                    end
                endcase
            end
        end
        start     <= nxt_start;
        pixel     <= nxt_pix;
        cfg_we    <= nxt_we;
        cfg_addr  <= nxt_addr;
        cfg_wdata <= nxt_data;
    end

    // ------------------------------------------------------------------
    // monitor, predictor update and watchdog count, at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n)
        begin
            // result side first: a pixel taken this edge cannot come out yet
            if (done)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %02h %02h %02h at %0t",
                                 result.chan0_out, result.chan1_out, result.chan2_out, $time);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (result.chan0_out !== want.chan0_out ||
                        result.chan1_out !== want.chan1_out ||
                        result.chan2_out !== want.chan2_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %02h %02h %02h, got %02h %02h %02h",
                                     $time, want.chan0_out, want.chan1_out, want.chan2_out,
                                     result.chan0_out, result.chan1_out, result.chan2_out);
                    end
                end
            end
            // input transfer: predict with the registers as they stand
            if (start && !busy)
                pixels_due.push_back(gamma_pixel(pixel));
            if (cfg_we)
            begin
                if (cfg_addr == REG_CHANNEL_SELECT)
                    sel_model = cfg_wdata[1:0];
                else
                    igamma_model = cfg_wdata;
            end
            if ((start && !busy) || done || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        pix_taken <= rst_n && start && !busy;
    end

    // watchdog: too long with no transfer anywhere
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog expired after %0d quiet cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [1:0]  sel;
        logic [15:0] ig;
        int          gap;
        int          n_pix;
        build_exp2_coef();

        // directed: reset settings, unity gamma on channel 0
        plan_pixel(8'd0,   8'd0,   8'd0,   0);
        plan_pixel(8'd255, 8'd255, 8'd255, 0);
        plan_pixel(8'd1,   8'd128, 8'd254, 0);
        plan_pixel(8'd128, 8'd1,   8'd77,  0);
        // gamma 2 on channel 1
        plan_config(CH1, 16'd2048);
        plan_pixel(8'd0,   8'd0,   8'd0,   0);
        plan_pixel(8'd13,  8'd255, 8'd13,  0);
        plan_pixel(8'd200, 8'd64,  8'd9,   0);
        // zero inverse gamma on channel 2: any nonzero value saturates
        plan_config(CH2, 16'd0);
        plan_pixel(8'd5,   8'd5,   8'd0,   0);
        plan_pixel(8'd5,   8'd5,   8'd1,   0);
        plan_pixel(8'd5,   8'd5,   8'd255, 0);
        // largest inverse gamma: small values fall off to zero
        plan_config(CH0, 16'hffff);
        plan_pixel(8'd1,   8'd3,   8'd3,   0);
        plan_pixel(8'd100, 8'd3,   8'd3,   0);
        plan_pixel(8'd254, 8'd3,   8'd3,   0);
        plan_pixel(8'd255, 8'd3,   8'd3,   0);
        // smallest nonzero inverse gamma
        plan_config(CH1, 16'd1);
        plan_pixel(8'd7,   8'd1,   8'd7,   0);
        plan_pixel(8'd7,   8'd128, 8'd7,   0);
        // no channel selected: straight pass-through
        plan_config(CH_NONE, 16'd8192);
        plan_pixel(8'd0,   8'd128, 8'd255, 0);
        plan_pixel(8'd255, 8'd0,   8'd1,   0);
        plan_pixel(8'haa,  8'h55,  8'hf0,  0);

        // random phases: gap pattern none, heavy, none, light
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                1:       gap = 49;
                3:       gap = 24;
                default: gap = 0;
            endcase
            sel   = 2'($urandom_range(0, 3));
            ig    = pick_igamma();
            plan_config(sel, ig);
            n_pix = 92 + $urandom_range(0, 6);
            for (int i = 0; i < n_pix; i++)
                plan_pixel(pick_level(), pick_level(), pick_level(), gap);
        end

        // wait for the plan to run dry and every result to come home
        while (input_plan.size() != 0 || start || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE + 2) @(posedge clk);

        if (pixels_due.size() != 0)
        begin
            $display("%0d predicted pixels never came out", pixels_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
